[hdl/rmr_pkg.sv]
// Shared types, constants and fixed-point helpers for the ray mirror reflection block.
package rmr_pkg;

  localparam int FRAC_BITS = 16;
  // Product of two 32-bit values after the fraction shift.
  localparam int TRUNC_W   = 64 - FRAC_BITS;
  // Sum of three truncated products.
  localparam int DOT_W     = TRUNC_W + 2;
  // 32-bit value plus one truncated product.
  localparam int SUM_W     = TRUNC_W + 1;
  // Reflection scale 2*|D.N| is held in 0 .. 2^31-1.
  localparam int SCALE_W   = 31;
  localparam int LATENCY   = 7;

  typedef logic signed [31:0] fx_t;

  typedef struct packed {
    fx_t        origin_x;
    fx_t        origin_y;
    fx_t        origin_z;
    fx_t        dir_x;
    fx_t        dir_y;
    fx_t        dir_z;
    fx_t        normal_x;
    fx_t        normal_y;
    fx_t        normal_z;
    fx_t        hit_distance;
    logic [7:0] bounce_budget;
  } rmr_in_t;

  typedef struct packed {
    fx_t        new_origin_x;
    fx_t        new_origin_y;
    fx_t        new_origin_z;
    fx_t        refl_x;
    fx_t        refl_y;
    fx_t        refl_z;
    logic [7:0] budget_left;
  } rmr_out_t;

  localparam logic signed [63:0]      TRUNC_BIAS = 64'((64'sd1 <<< FRAC_BITS) - 64'sd1);
  localparam logic signed [SUM_W-1:0] SAT_HI     = SUM_W'(64'sd2147483647);
  localparam logic signed [SUM_W-1:0] SAT_LO     = SUM_W'(-64'sd2147483648);

  // Drop the fraction bits, rounding toward zero.
  function automatic logic signed [TRUNC_W-1:0] trunc_fx(input logic signed [63:0] p);
    logic signed [63:0] biased;
    biased = p + (p[63] ? TRUNC_BIAS : 64'sd0);
    return biased[63:FRAC_BITS];
  endfunction

  // Clamp to the 32-bit signed range.
  function automatic fx_t sat_fx(input logic signed [SUM_W-1:0] v);
    fx_t res;
    if (v > SAT_HI) begin
      res = 32'sh7FFF_FFFF;
    end else if (v < SAT_LO) begin
      res = 32'sh8000_0000;
    end else begin
      res = v[31:0];
    end
    return res;
  endfunction

endpackage

[hdl/rmr_lane.sv]
// One vector component lane: hit point and reflected direction for x, y or z.
module rmr_lane
  import rmr_pkg::*;
(
  input  logic                      clk,
  input  fx_t                       orig_i,
  input  fx_t                       dir_i,
  input  fx_t                       norm_i,
  input  fx_t                       dist_i,
  input  logic [SCALE_W-1:0]        scale_i,   // from merge, aligned to stage 4
  output logic signed [TRUNC_W-1:0] dot_term_o, // stage 2
  output fx_t                       new_orig_o, // stage 7
  output fx_t                       refl_o      // stage 7
);

  logic signed [63:0]      prod_dn_r, prod_dt_r, prod_sn_r;
  logic signed [TRUNC_W-1:0] tdn_r, tdt_r, tsn_r;
  fx_t o1_r, o2_r;
  fx_t d1_r, d2_r, d3_r, d4_r, d5_r, d6_r;
  fx_t n1_r, n2_r, n3_r, n4_r;
  fx_t org3_r, org4_r, org5_r, org6_r, org7_r;
  fx_t refl_r;

  logic signed [SUM_W-1:0] org_sum_nxt, refl_sum_nxt;

  assign org_sum_nxt  = SUM_W'(o2_r) + SUM_W'(tdt_r);
  assign refl_sum_nxt = SUM_W'(d6_r) + SUM_W'(tsn_r);

  always_ff @(posedge clk) begin
    // stage 1: D*N and D*t
    prod_dn_r <= 64'(dir_i) * 64'(norm_i);
    prod_dt_r <= 64'(dir_i) * 64'(dist_i);
    o1_r      <= orig_i;
    d1_r      <= dir_i;
    n1_r      <= norm_i;
    // stage 2: fraction shift
    tdn_r     <= trunc_fx(prod_dn_r);
    tdt_r     <= trunc_fx(prod_dt_r);
    o2_r      <= o1_r;
    d2_r      <= d1_r;
    n2_r      <= n1_r;
    // stage 3: hit point
    org3_r    <= sat_fx(org_sum_nxt);
    d3_r      <= d2_r;
    n3_r      <= n2_r;
    // stage 4: wait for scale
    org4_r    <= org3_r;
    d4_r      <= d3_r;
    n4_r      <= n3_r;
    // stage 5: s*N
    prod_sn_r <= 64'(signed'({1'b0, scale_i})) * 64'(n4_r);
    org5_r    <= org4_r;
    d5_r      <= d4_r;
    // stage 6
    tsn_r     <= trunc_fx(prod_sn_r);
    org6_r    <= org5_r;
    d6_r      <= d5_r;
    // stage 7: reflected direction
    refl_r    <= sat_fx(refl_sum_nxt);
    org7_r    <= org6_r;
  end

  assign dot_term_o = tdn_r;
  assign new_orig_o = org7_r;
  assign refl_o     = refl_r;

endmodule

[hdl/rmr_merge.sv]
// Combines the lanes' dot-product terms into the reflection scale 2*|D.N|.
module rmr_merge
  import rmr_pkg::*;
(
  input  logic                      clk,
  input  logic signed [TRUNC_W-1:0] term_x_i,
  input  logic signed [TRUNC_W-1:0] term_y_i,
  input  logic signed [TRUNC_W-1:0] term_z_i,
  output logic [SCALE_W-1:0]        scale_o
);

  logic signed [DOT_W-1:0] dot_r, dot_nxt;
  logic [DOT_W-1:0]        abs_dot;
  logic [SCALE_W-1:0]      scale_r, scale_nxt;

  assign dot_nxt = DOT_W'(term_x_i) + DOT_W'(term_y_i) + DOT_W'(term_z_i);
  assign abs_dot = dot_r[DOT_W-1] ? DOT_W'(-dot_r) : DOT_W'(dot_r);
  // |P| >= 2^30 means 2|P| leaves the 31-bit range
  assign scale_nxt = (|abs_dot[DOT_W-1:SCALE_W-1]) ? {SCALE_W{1'b1}}
                                                   : {abs_dot[SCALE_W-2:0], 1'b0};

  always_ff @(posedge clk) begin
    dot_r   <= dot_nxt;   // stage 3
    scale_r <= scale_nxt; // stage 4
  end

  assign scale_o = scale_r;

endmodule

[hdl/ray_mirror_reflection_top.sv]
// Top level of the ray mirror reflection block: three component lanes and a merge stage.
//
// One ray request is taken every clock cycle: busy is always low and start
// alone marks a request. Each request produces exactly one result, on
// out_ray with out_valid high for one cycle. Results leave in request
// order. The receiver cannot stall, so it must take every result in the
// cycle it appears. The seven register stages come from two multiply
// levels in series: D*N and D*t with their fraction shift in each lane
// (stages 1-2), then the dot-product merge and scale (stages 3-4), then s*N
// and its fraction shift in each lane (stages 5-6), then the final saturating
// sum (stage 7).
// All vector values are signed Q16.16; products round toward zero, sums
// saturate to the 32-bit range and the bounce budget decrement is held at zero.
module ray_mirror_reflection_top
  import rmr_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     start,
  output logic     busy,
  input  rmr_in_t  in_ray,
  output logic     out_valid,
  output rmr_out_t out_ray
);

  logic accept;
  logic [LATENCY-1:0] valid_r, valid_nxt;
  logic [7:0] budget_r [LATENCY];

  fx_t lane_orig [3];
  fx_t lane_dir  [3];
  fx_t lane_norm [3];
  fx_t lane_new_orig [3];
  fx_t lane_refl [3];
  logic signed [TRUNC_W-1:0] lane_term [3];
  logic [SCALE_W-1:0] scale;

  // fully pipelined, never refuses a request
  assign busy   = 1'b0;
  assign accept = start && !busy;

  assign valid_nxt = {valid_r[LATENCY-2:0], accept};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  // budget travels alongside the lanes; decrement held at zero
  always_ff @(posedge clk) begin
    budget_r[0] <= (in_ray.bounce_budget == 8'd0) ? 8'd0 : in_ray.bounce_budget - 8'd1;
    for (int i = 1; i < LATENCY; i++) begin
      budget_r[i] <= budget_r[i-1];
    end
  end

  assign lane_orig[0] = in_ray.origin_x;
  assign lane_orig[1] = in_ray.origin_y;
  assign lane_orig[2] = in_ray.origin_z;
  assign lane_dir[0]  = in_ray.dir_x;
  assign lane_dir[1]  = in_ray.dir_y;
  assign lane_dir[2]  = in_ray.dir_z;
  assign lane_norm[0] = in_ray.normal_x;
  assign lane_norm[1] = in_ray.normal_y;
  assign lane_norm[2] = in_ray.normal_z;

  for (genvar g = 0; g < 3; g++) begin : g_lane
    rmr_lane u_lane (
      .clk        (clk),
      .orig_i     (lane_orig[g]),
      .dir_i      (lane_dir[g]),
      .norm_i     (lane_norm[g]),
      .dist_i     (in_ray.hit_distance),
      .scale_i    (scale),
      .dot_term_o (lane_term[g]),
      .new_orig_o (lane_new_orig[g]),
      .refl_o     (lane_refl[g])
    );
  end

  // lanes' D.N terms meet here; scale goes back to all three lanes
  rmr_merge u_merge (
    .clk      (clk),
    .term_x_i (lane_term[0]),
    .term_y_i (lane_term[1]),
    .term_z_i (lane_term[2]),
    .scale_o  (scale)
  );

  assign out_valid            = valid_r[LATENCY-1];
  assign out_ray.new_origin_x = lane_new_orig[0];
  assign out_ray.new_origin_y = lane_new_orig[1];
  assign out_ray.new_origin_z = lane_new_orig[2];
  assign out_ray.refl_x       = lane_refl[0];
  assign out_ray.refl_y       = lane_refl[1];
  assign out_ray.refl_z       = lane_refl[2];
  assign out_ray.budget_left  = budget_r[LATENCY-1];

  // a result only follows a matching earlier accepted request
  a_valid_follows_req: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(accept, LATENCY))
    else $error("result without matching request");

  // budget decrement, held at zero
  a_budget: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_ray.budget_left ==
      (($past(in_ray.bounce_budget, LATENCY) == 8'd0) ? 8'd0
        : $past(in_ray.bounce_budget, LATENCY) - 8'd1))
    else $error("budget_left wrong");

  // zero normal leaves the direction untouched
  a_zero_normal: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && $past(in_ray.normal_x == 32'sd0 && in_ray.normal_y == 32'sd0 &&
                       in_ray.normal_z == 32'sd0, LATENCY)
    |-> out_ray.refl_x == $past(in_ray.dir_x, LATENCY) &&
        out_ray.refl_y == $past(in_ray.dir_y, LATENCY) &&
        out_ray.refl_z == $past(in_ray.dir_z, LATENCY))
    else $error("direction changed by zero normal");

  // zero distance keeps the origin
  a_zero_dist: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && $past(in_ray.hit_distance == 32'sd0, LATENCY)
    |-> out_ray.new_origin_x == $past(in_ray.origin_x, LATENCY) &&
        out_ray.new_origin_y == $past(in_ray.origin_y, LATENCY) &&
        out_ray.new_origin_z == $past(in_ray.origin_z, LATENCY))
    else $error("origin moved with zero distance");

endmodule

[tb/sv/tb_ray_mirror_reflection_top.sv]
// Self-checking testbench for the ray mirror reflection block: directed and random rays.
module tb_ray_mirror_reflection_top;
  timeunit 1ns;
  timeprecision 1ps;

  import rmr_pkg::*;

  // Q16.16 landmarks
  localparam fx_t FX_ONE  = 32'sh0001_0000;
  localparam fx_t FX_HALF = 32'sh0000_8000;
  localparam fx_t FX_MAX  = 32'sh7FFF_FFFF;
  localparam fx_t FX_MIN  = 32'sh8000_0000;
  localparam fx_t FX_LSB  = 32'sh0000_0001;

  localparam longint SCALE_CAP = 64'sh0000_0000_7FFF_FFFF;

  logic     clk   = 1'b0;
  logic     rst_n = 1'b0;
  logic     start = 1'b0;
  logic     busy;
  rmr_in_t  in_ray = '0;
  logic     out_valid;
  rmr_out_t out_ray;

  // Reflections predicted for accepted requests, oldest first
  rmr_out_t pending_reflections[$];
  int       mismatch_count = 0;
  // Chance, in percent, that the sender leaves a cycle empty before a request
  int       send_idle_pct  = 0;

  ray_mirror_reflection_top u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_ray    (in_ray),
    .out_valid (out_valid),
    .out_ray   (out_ray)
  );

  always #5 clk = ~clk;

  // ---------------------------------------------------------------------------
  // Prediction
  // ---------------------------------------------------------------------------

  // Exact product of two fixed-point values with the fraction dropped towards
  // zero. Operands stay within 32 bits, so the product never leaves 63 bits.
  function automatic longint fx_product(input longint a, input longint b);
    longint p;
    p = a * b;
    if (p < 0) begin
      return -((-p) >>> FRAC_BITS);
    end
    return p >>> FRAC_BITS;
  endfunction

  function automatic fx_t clamp_fx(input longint v);
    if (v > longint'(FX_MAX)) begin
      return FX_MAX;
    end else if (v < longint'(FX_MIN)) begin
      return FX_MIN;
    end
    return fx_t'(v);
  endfunction

  // Hit point O + D*t, reflected direction D + 2|D.N|N, budget less one held at zero
  function automatic rmr_out_t reflect_ray(input rmr_in_t ray);
    longint   org[3];
    longint   dir[3];
    longint   nrm[3];
    longint   hit_dist;
    longint   dot;
    longint   scale;
    fx_t      hit[3];
    fx_t      bounce[3];
    rmr_out_t res;
    org[0] = ray.origin_x;  org[1] = ray.origin_y;  org[2] = ray.origin_z;
    dir[0] = ray.dir_x;     dir[1] = ray.dir_y;     dir[2] = ray.dir_z;
    nrm[0] = ray.normal_x;  nrm[1] = ray.normal_y;  nrm[2] = ray.normal_z;
    hit_dist = ray.hit_distance;
    // Dot product kept wide, then folded to its magnitude
    dot = fx_product(dir[0], nrm[0]) + fx_product(dir[1], nrm[1])
        + fx_product(dir[2], nrm[2]);
    if (dot < 0) begin
      dot = -dot;
    end
    scale = 2 * dot;
    if (scale > SCALE_CAP) begin
      scale = SCALE_CAP;
    end
    for (int i = 0; i < 3; i++) begin
      hit[i]    = clamp_fx(org[i] + fx_product(dir[i], hit_dist));
      bounce[i] = clamp_fx(dir[i] + fx_product(scale, nrm[i]));
    end
    res.new_origin_x = hit[0];
    res.new_origin_y = hit[1];
    res.new_origin_z = hit[2];
    res.refl_x       = bounce[0];
    res.refl_y       = bounce[1];
    res.refl_z       = bounce[2];
    res.budget_left  = (ray.bounce_budget == 8'd0) ? 8'd0 : ray.bounce_budget - 8'd1;
    return res;
  endfunction

  // ---------------------------------------------------------------------------
  // Checking
  // ---------------------------------------------------------------------------

  task automatic check_field(input string name, input longint want, input longint got);
    if (want != got) begin
      mismatch_count++;
      if (mismatch_count <= 10) begin
        $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
      end
    end
  endtask

  task automatic compare_reflection(input rmr_out_t want, input rmr_out_t got);
    check_field("new_origin_x", want.new_origin_x, got.new_origin_x);
    check_field("new_origin_y", want.new_origin_y, got.new_origin_y);
    check_field("new_origin_z", want.new_origin_z, got.new_origin_z);
    check_field("refl_x",       want.refl_x,       got.refl_x);
    check_field("refl_y",       want.refl_y,       got.refl_y);
    check_field("refl_z",       want.refl_z,       got.refl_z);
    check_field("budget_left",  want.budget_left,  got.budget_left);
  endtask

  // Results are checked before the request of the same edge is logged; with a
  // registered pipeline in between, a request can never meet its own result on one edge.
  // Everything here reads values from before the edge, so the order of events
  // within the step does not matter.
  always @(posedge clk) begin
    rmr_out_t want;
    if (rst_n) begin
      if (out_valid) begin
        if (pending_reflections.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= 10) begin
            $display("%0t: result with no request outstanding", $time);
          end
        end else begin
          want = pending_reflections.pop_front();
          compare_reflection(want, out_ray);
        end
      end
      if (start && !busy) begin
        pending_reflections.push_back(reflect_ray(in_ray));
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------

  function automatic rmr_in_t make_ray(input fx_t ox, input fx_t oy, input fx_t oz,
                                       input fx_t dx, input fx_t dy, input fx_t dz,
                                       input fx_t nx, input fx_t ny, input fx_t nz,
                                       input fx_t hit_dist, input logic [7:0] budget);
    rmr_in_t ray;
    ray.origin_x      = ox;
    ray.origin_y      = oy;
    ray.origin_z      = oz;
    ray.dir_x         = dx;
    ray.dir_y         = dy;
    ray.dir_z         = dz;
    ray.normal_x      = nx;
    ray.normal_y      = ny;
    ray.normal_z      = nz;
    ray.hit_distance  = hit_dist;
    ray.bounce_budget = budget;
    return ray;
  endfunction

  // Presents one request and returns at the edge that takes it. An idle gap,
  // if any, goes in front so that start is only ever changed once per edge.
  task automatic send_ray(input rmr_in_t ray);
    if (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
      while ($urandom_range(99) < send_idle_pct) begin
        @(posedge clk);
      end
    end
    start  <= 1'b1;
    in_ray <= ray;
    @(posedge clk);
    while (busy) begin
      @(posedge clk);
    end
  endtask

  // Sender holds off until every outstanding result has come back. The first
  // edge lets the final request land in the queue before it is looked at.
  task automatic wait_all_returned();
    start <= 1'b0;
    @(posedge clk);
    while (pending_reflections.size() != 0) begin
      @(posedge clk);
    end
    repeat (LATENCY + 2) @(posedge clk);
  endtask

  // Modest scene coordinates, full-range noise, values near the rails and tiny values
  function automatic fx_t random_fx();
    fx_t v;
    case ($urandom_range(9))
      0, 1, 2, 3: v = fx_t'($urandom_range(32'h0020_0000)) - 32'sh0010_0000;
      4, 5, 6:    v = fx_t'($urandom);
      7:          v = FX_MAX - fx_t'($urandom_range(3));
      8:          v = FX_MIN + fx_t'($urandom_range(3));
      default:    v = fx_t'($urandom_range(510)) - 32'sd255;
    endcase
    return v;
  endfunction

  function automatic rmr_in_t random_ray();
    logic [7:0] budget;
    case ($urandom_range(7))
      0:       budget = 8'd0;
      1:       budget = 8'd1;
      2:       budget = 8'd255;
      default: budget = 8'($urandom_range(255));
    endcase
    return make_ray(random_fx(), random_fx(), random_fx(),
                    random_fx(), random_fx(), random_fx(),
                    random_fx(), random_fx(), random_fx(),
                    random_fx(), budget);
  endfunction

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Field rails: all zero, all high, all low, and sums driven past either rail
  task automatic test_extreme_values();
    send_ray(make_ray('0, '0, '0, '0, '0, '0, '0, '0, '0, '0, 8'd0));
    send_ray(make_ray(FX_MAX, FX_MAX, FX_MAX, FX_MAX, FX_MAX, FX_MAX,
                      FX_MAX, FX_MAX, FX_MAX, FX_MAX, 8'd255));
    send_ray(make_ray(FX_MIN, FX_MIN, FX_MIN, FX_MIN, FX_MIN, FX_MIN,
                      FX_MIN, FX_MIN, FX_MIN, FX_MIN, 8'd1));
    // hit point runs off the top rail on both x and y
    send_ray(make_ray(FX_MAX, FX_MIN, '0, FX_MAX, FX_MAX, FX_ONE,
                      '0, FX_ONE, '0, FX_MAX, 8'd7));
    send_ray(make_ray(FX_MIN, FX_MAX, FX_ONE, FX_MAX, FX_MIN, FX_MIN,
                      FX_MIN, FX_MAX, FX_MIN, FX_MIN, 8'd128));
    // huge dot product: scale pinned at its ceiling
    send_ray(make_ray(FX_ONE, '0, '0, FX_MIN, FX_MIN, FX_MIN,
                      FX_ONE, -FX_ONE, FX_HALF, FX_ONE, 8'd3));
  endtask

  // Budget held at zero rather than wrapping, and plain decrements elsewhere
  task automatic test_budget_floor();
    logic [7:0] budgets[5] = '{8'd0, 8'd1, 8'd2, 8'd128, 8'd255};
    foreach (budgets[i]) begin
      send_ray(make_ray(FX_ONE, 2 * FX_ONE, 3 * FX_ONE, '0, -FX_ONE, '0,
                        '0, FX_ONE, '0, 32'sh0002_8000, budgets[i]));
    end
  endtask

  // Facing and away-facing normals, unnormalised and zero normals, and
  // products that must round towards zero rather than down
  task automatic test_normal_cases();
    send_ray(make_ray('0, '0, '0, '0, -FX_ONE, '0, '0, FX_ONE, '0, FX_ONE, 8'd4));
    send_ray(make_ray('0, '0, '0, '0, FX_ONE, '0, '0, FX_ONE, '0, FX_ONE, 8'd4));
    send_ray(make_ray(FX_ONE, '0, -FX_ONE, FX_ONE, -FX_ONE, '0,
                      '0, 2 * FX_ONE, '0, FX_HALF, 8'd9));
    send_ray(make_ray('0, '0, '0, FX_ONE, -FX_ONE, FX_HALF, '0, '0, '0, -FX_ONE, 8'd9));
    // a product of minus one LSB squared-away: floor would give -1, trunc gives 0
    send_ray(make_ray('0, '0, '0, -FX_LSB, FX_LSB, -FX_LSB,
                      FX_LSB, FX_LSB, FX_LSB, FX_LSB, 8'd2));
    send_ray(make_ray(32'sh0003_0001, -32'sh0002_0003, FX_LSB, -32'sh0001_8001, FX_HALF,
                      32'sh0000_4001, 32'sh0000_B505, -32'sh0000_B505, '0,
                      -32'sh0004_2001, 8'd200));
    send_ray(make_ray(-FX_ONE, FX_ONE, '0, 32'sh0000_B505, -32'sh0000_B505, '0,
                      -FX_ONE, '0, '0, 32'sh0010_0000, 8'd1));
  endtask

  task automatic test_random_rays(input int count, input int idle_pct);
    send_idle_pct = idle_pct;
    repeat (count) begin
      send_ray(random_ray());
    end
    send_idle_pct = 0;
  endtask

  // ---------------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------------

  initial begin
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    test_extreme_values();
    test_budget_floor();
    test_normal_cases();
    // the sender holds off once with everything still in flight
    wait_all_returned();

    test_random_rays(580, 8);
    wait_all_returned();
    test_random_rays(580, 48);
    wait_all_returned();
    test_random_rays(580, 0);
    wait_all_returned();

    if (mismatch_count == 0 && pending_reflections.size() == 0) begin
      $display("ray_mirror_reflection_top test passed");
    end else begin
      $display("ray_mirror_reflection_top test failed");
    end
    $finish;
  end

  // Watchdog, far beyond the slowest correct run
  initial begin
    #2_000_000;
    $display("ray_mirror_reflection_top test failed");
    $finish;
  end

endmodule

[filelist.f]
hdl/rmr_pkg.sv
hdl/rmr_lane.sv
hdl/rmr_merge.sv
hdl/ray_mirror_reflection_top.sv
tb/sv/tb_ray_mirror_reflection_top.sv
